// ===== design/status_led_effect_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Status LED effect controller assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_EFFECT_CONTROLLER_MACROS_SVH
`define STATUS_LED_EFFECT_CONTROLLER_MACROS_SVH

// same-cycle implication
`define SLEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slec assertion failed");

// next-cycle implication
`define SLEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slec assertion failed");

`endif

// ===== design/slec_pkg.sv =====
// ----------------------------------------------------------------------------
// Status LED effect controller package
// Mode codes, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package slec_pkg;

  typedef enum logic [2:0] {
    MODE_OFF   = 3'd0,
    MODE_ON    = 3'd1,
    MODE_FLASH = 3'd2,
    MODE_FAST  = 3'd3,
    MODE_SHORT = 3'd4,
    MODE_LONG  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    CFG_FLASH_IVL = 3'd0,
    CFG_FAST_IVL  = 3'd1,
    CFG_SHORT_MS  = 3'd2,
    CFG_LONG_MS   = 3'd3,
    CFG_MAX_SHORT = 3'd4,
    CFG_MAX_LONG  = 3'd5
  } cfg_idx_e;

  localparam logic [15:0] RST_FLASH_IVL = 16'd500;
  localparam logic [15:0] RST_FAST_IVL  = 16'd100;
  localparam logic [15:0] RST_SHORT_MS  = 16'd50;
  localparam logic [15:0] RST_LONG_MS   = 16'd500;
  localparam logic [7:0]  RST_MAX_BLINK = 8'd3;
  localparam logic [7:0]  BLINK_CNT_MAX = 8'd255;

  typedef struct packed {
    logic [15:0] flash_interval_ms;
    logic [15:0] fast_flash_interval_ms;
    logic [15:0] short_blink_ms;
    logic [15:0] long_blink_ms;
    logic [7:0]  max_short_blinks;
    logic [7:0]  max_long_blinks;
  } cfg_t;

endpackage

// ===== design/slec_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Status LED effect controller configuration registers
// Six timing and count registers written over the config channel.
// ----------------------------------------------------------------------------
module slec_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  output slec_pkg::cfg_t cfg_o
);
  import slec_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flash_interval_ms      <= RST_FLASH_IVL;
      cfg_q.fast_flash_interval_ms <= RST_FAST_IVL;
      cfg_q.short_blink_ms         <= RST_SHORT_MS;
      cfg_q.long_blink_ms          <= RST_LONG_MS;
      cfg_q.max_short_blinks       <= RST_MAX_BLINK;
      cfg_q.max_long_blinks        <= RST_MAX_BLINK;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FLASH_IVL: cfg_q.flash_interval_ms      <= cfg_data_i;
        CFG_FAST_IVL:  cfg_q.fast_flash_interval_ms <= cfg_data_i;
        CFG_SHORT_MS:  cfg_q.short_blink_ms         <= cfg_data_i;
        CFG_LONG_MS:   cfg_q.long_blink_ms          <= cfg_data_i;
        CFG_MAX_SHORT: cfg_q.max_short_blinks       <= cfg_data_i[7:0];
        CFG_MAX_LONG:  cfg_q.max_long_blinks        <= cfg_data_i[7:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/slec_fx_core.sv =====
// ----------------------------------------------------------------------------
// Status LED effect controller effect core
// Mode, blink count, ms counter and per-effect timers; one item per cycle when accepted.
// ----------------------------------------------------------------------------
module slec_fx_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_acc_i,
  input  logic           kind_i,
  input  logic [2:0]     mode_i,
  input  slec_pkg::cfg_t cfg_i,
  output logic           led_next_o
);
  import slec_pkg::*;

  logic [2:0]  cur_mode_q, cur_mode_d;
  logic [7:0]  blink_cnt_q, blink_cnt_d;
  logic [31:0] now_q, now_d;
  logic [31:0] stamp_q [4];
  logic [31:0] stamp_d [4];
  logic [3:0]  level_q, level_d;
  logic        led_q, led_d;

  logic [2:0]  fx_sub;
  logic [1:0]  fx;
  logic [15:0] interval;
  logic [7:0]  max_cnt;
  logic [7:0]  clamped;
  logic [31:0] now_inc;
  logic [31:0] elapsed;
  logic        passed;

  // effect slot: flash 0, fast 1, short 2, long 3
  assign fx_sub  = cur_mode_q - MODE_FLASH;
  assign fx      = fx_sub[1:0];
  assign now_inc = now_q + 32'd1;
  assign elapsed = now_inc - stamp_q[fx];
  assign passed  = elapsed >= {16'd0, interval};
  assign max_cnt = fx[0] ? cfg_i.max_long_blinks : cfg_i.max_short_blinks;
  assign clamped = (blink_cnt_q > max_cnt) ? max_cnt : blink_cnt_q;

  always_comb begin
    unique case (fx)
      2'd0: interval = cfg_i.flash_interval_ms;
      2'd1: interval = cfg_i.fast_flash_interval_ms;
      2'd2: interval = cfg_i.short_blink_ms;
      2'd3: interval = cfg_i.long_blink_ms;
      default: interval = cfg_i.flash_interval_ms;
    endcase
  end

  always_comb begin
    cur_mode_d  = cur_mode_q;
    blink_cnt_d = blink_cnt_q;
    now_d       = now_q;
    stamp_d     = stamp_q;
    level_d     = level_q;
    led_d       = led_q;
    if (kind_i) begin
      if (mode_i != cur_mode_q) begin
        cur_mode_d  = mode_i;
        blink_cnt_d = 8'd1;
      end else if (blink_cnt_q != BLINK_CNT_MAX) begin
        blink_cnt_d = blink_cnt_q + 8'd1;
      end
    end else begin
      now_d = now_inc;
      unique case (cur_mode_q)
        MODE_OFF: led_d = 1'b0;
        MODE_ON:  led_d = 1'b1;
        MODE_FLASH, MODE_FAST: begin
          if (passed) begin
            stamp_d[fx] = now_inc;
            level_d[fx] = ~level_q[fx];
          end
          led_d = level_d[fx];
        end
        MODE_SHORT, MODE_LONG: begin
          if (passed) begin
            stamp_d[fx] = now_inc;
            if (level_q[fx]) begin
              level_d[fx] = 1'b0;
            end else if (clamped != 8'd0) begin
              blink_cnt_d = clamped - 8'd1;
              level_d[fx] = 1'b1;
            end else begin
              blink_cnt_d = clamped;
            end
          end
          led_d = level_d[fx];
        end
        default: ;  // unused codes hold the LED
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode_q  <= MODE_OFF;
      blink_cnt_q <= 8'd0;
      now_q       <= 32'd0;
      stamp_q     <= '{default: '0};
      level_q     <= 4'd0;
      led_q       <= 1'b0;
    end else if (item_acc_i) begin
      cur_mode_q  <= cur_mode_d;
      blink_cnt_q <= blink_cnt_d;
      now_q       <= now_d;
      stamp_q     <= stamp_d;
      level_q     <= level_d;
      led_q       <= led_d;
    end
  end

  assign led_next_o = led_d;

endmodule

// ===== design/slec_out_buf.sv =====
// ----------------------------------------------------------------------------
// Status LED effect controller output buffer
// Result register plus one skid entry so input keeps flowing under stall.
// ----------------------------------------------------------------------------
module slec_out_buf (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic led_i,
  output logic in_stall_o,
  output logic item_acc_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic out_led_on_o
);
  logic out_valid_q, skid_valid_q;
  logic out_led_q, skid_led_q;
  logic out_take;

  assign out_take   = out_valid_q & ~out_stall_i;
  assign item_acc_o = in_valid_i & ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_q <= item_acc_o;
    end else if (item_acc_o) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_led_q <= skid_led_q;
      end
    end else if (!out_valid_q || out_take) begin
      out_led_q <= led_i;
    end else if (item_acc_o) begin
      skid_led_q <= led_i;
    end
  end

  assign in_stall_o   = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_led_on_o = out_led_q;

endmodule

// ===== design/status_led_effect_controller.sv =====
// ----------------------------------------------------------------------------
// Status LED effect controller
// Off / on / flash / fast flash / short and long blink for one status LED.
// ----------------------------------------------------------------------------
// Takes one item per clock unless stalled: a tick (kind 0, one millisecond)
// or a set-mode request (kind 1). Each item is fully processed in the cycle
// it is accepted; its LED level goes to the result register, or to a
// one-entry skid stage while a result is stalled, which keeps the input
// open, so stall on the input only appears after two results back up.
// Throughput is one item per cycle unless stalled, set by the single 32-bit
// timer subtract-and-compare in the effect core. Config registers are
// always ready and should be written only while no items are in flight.
module status_led_effect_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_kind_i,
  input  logic [2:0]  in_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_led_on_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import slec_pkg::*;

  cfg_t cfg;
  logic item_acc;
  logic led_next;

  assign cfg_ready_o = 1'b1;

  slec_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  slec_fx_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_acc_i (item_acc),
    .kind_i     (in_kind_i),
    .mode_i     (in_mode_i),
    .cfg_i      (cfg),
    .led_next_o (led_next)
  );

  slec_out_buf u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .led_i        (led_next),
    .in_stall_o   (in_stall_o),
    .item_acc_o   (item_acc),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_led_on_o (out_led_on_o)
  );

endmodule

// ===== design/slec_checker.sv =====
// ----------------------------------------------------------------------------
// Status LED effect controller checker
// Port-level properties of the result buffering, bound to the top level.
// ----------------------------------------------------------------------------
`include "status_led_effect_controller_macros.svh"

module slec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        out_led_on_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);
  logic in_take;
  logic out_free;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;

  // stalled result stays put
  `SLEC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_led_on_o))
  // input only backs up behind a held result
  `SLEC_ASSERT_NOW(a_stall_needs_result, in_stall_o, out_valid_o)
  // an item entering a free result slot shows up next cycle
  `SLEC_ASSERT_NEXT(a_item_to_result, in_take && out_free, out_valid_o)
  // config channel never blocks
  `SLEC_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind status_led_effect_controller slec_checker u_slec_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status LED effect controller testbench
// Drives tick and set-mode items against a cycle-free model of the LED
// effects, checks every LED result in order, and sweeps the interval and
// blink-limit registers across their extremes under random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import slec_pkg::*;

  localparam logic       KIND_TICK   = 1'b0;
  localparam logic       KIND_SET    = 1'b1;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam logic [2:0] CFG_SPARE6  = 3'd6;
  localparam logic [2:0] CFG_SPARE7  = 3'd7;
  localparam int         FX_FLASH    = 0;
  localparam int         FX_FAST     = 1;
  localparam int         FX_SHORT    = 2;
  localparam int         FX_LONG     = 3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         HOLD_CYCLES = 80;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_kind_i   = 1'b0;
  logic [2:0]  in_mode_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_led_on_o;
  logic        cfg_ready_o;

  status_led_effect_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_kind_i   (in_kind_i),
    .in_mode_i   (in_mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_led_on_o(out_led_on_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model
  cfg_t        regs_model = '{RST_FLASH_IVL, RST_FAST_IVL, RST_SHORT_MS, RST_LONG_MS,
                              RST_MAX_BLINK, RST_MAX_BLINK};
  logic [2:0]  mode_model = MODE_OFF;
  logic [7:0]  blink_cnt  = '0;
  logic [31:0] now_ms     = '0;
  logic [31:0] fx_stamp [4] = '{default: '0};
  logic        fx_level [4] = '{default: 1'b0};
  logic        led_model  = 1'b0;

  logic led_expected [$];
  int   mismatches = 0;
  bit   idle_en    = 1'b1;
  int   hold_reqs  = 0;
  int   hold_seen  = 0;
  int   hold_left  = 0;
  int   stall_left = 0;
  int   cycles     = 0;

  function automatic logic timer_due(int fx, logic [15:0] ivl);
    if (now_ms - fx_stamp[fx] >= {16'd0, ivl}) begin
      fx_stamp[fx] = now_ms;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void step_flash(int fx, logic [15:0] ivl);
    if (timer_due(fx, ivl)) fx_level[fx] = ~fx_level[fx];
    led_model = fx_level[fx];
  endfunction

  function automatic void step_blink(int fx, logic [15:0] ms, logic [7:0] cap);
    if (fx_level[fx]) begin
      if (timer_due(fx, ms)) fx_level[fx] = 1'b0;
    end else if (timer_due(fx, ms)) begin
      if (blink_cnt > cap) blink_cnt = cap;
      if (blink_cnt != 8'd0) begin
        blink_cnt = blink_cnt - 8'd1;
        fx_level[fx] = 1'b1;
      end
    end
    led_model = fx_level[fx];
  endfunction

  function automatic logic predict_led(logic kind, logic [2:0] mode);
    if (kind == KIND_SET) begin
      if (mode_model != mode) begin
        mode_model = mode;
        blink_cnt  = 8'd1;
      end else if (blink_cnt != BLINK_CNT_MAX) begin
        blink_cnt = blink_cnt + 8'd1;
      end
    end else begin
      now_ms = now_ms + 32'd1;
      case (mode_model)
        MODE_OFF:   led_model = 1'b0;
        MODE_ON:    led_model = 1'b1;
        MODE_FLASH: step_flash(FX_FLASH, regs_model.flash_interval_ms);
        MODE_FAST:  step_flash(FX_FAST, regs_model.fast_flash_interval_ms);
        MODE_SHORT: step_blink(FX_SHORT, regs_model.short_blink_ms,
                               regs_model.max_short_blinks);
        MODE_LONG:  step_blink(FX_LONG, regs_model.long_blink_ms,
                               regs_model.max_long_blinks);
        default: ;  // spare codes hold the LED
      endcase
    end
    return led_model;
  endfunction

  function automatic void store_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      CFG_FLASH_IVL: regs_model.flash_interval_ms      = data;
      CFG_FAST_IVL:  regs_model.fast_flash_interval_ms = data;
      CFG_SHORT_MS:  regs_model.short_blink_ms         = data;
      CFG_LONG_MS:   regs_model.long_blink_ms          = data;
      CFG_MAX_SHORT: regs_model.max_short_blinks       = data[7:0];
      CFG_MAX_LONG:  regs_model.max_long_blinks        = data[7:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checker
  always @(negedge clk_i) begin
    logic want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (led_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: LED result %0b with no item outstanding", $realtime, out_led_on_o);
      end else begin
        want = led_expected.pop_front();
        if (out_led_on_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: led_on expected %0b actual %0b", $realtime, want, out_led_on_o);
        end
      end
    end
  end

  // receiver: random stall bursts plus requested long hold-offs
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen   <= hold_reqs;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 17);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_item(input logic kind, input logic [2:0] mode);
    bit taken;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i  <= kind;
    in_mode_i  <= mode;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    led_expected.push_back(predict_led(kind, mode));
  endtask

  task automatic tick();
    send_item(KIND_TICK, 3'($urandom_range(0, 7)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (led_expected.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high so back-to-back writes need no extra edge
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    store_reg(idx, data);
  endtask

  task automatic write_all(input cfg_t c);
    write_reg(CFG_FLASH_IVL, c.flash_interval_ms);
    write_reg(CFG_FAST_IVL, c.fast_flash_interval_ms);
    write_reg(CFG_SHORT_MS, c.short_blink_ms);
    write_reg(CFG_LONG_MS, c.long_blink_ms);
    // upper data bits are don't-care for the count limits
    write_reg(CFG_MAX_SHORT, {8'($urandom), c.max_short_blinks});
    write_reg(CFG_MAX_LONG, {8'($urandom), c.max_long_blinks});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_interval(int style);
    int r;
    r = $urandom_range(0, 19);
    if (style == 0) return 16'hFFFF;
    if (style == 1) return 16'd1;
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'($urandom);
    return 16'($urandom_range(1, 12));
  endfunction

  function automatic logic [7:0] pick_cap(int style);
    int r;
    r = $urandom_range(0, 19);
    if (style == 0) return BLINK_CNT_MAX;
    if (style == 1) return 8'd0;
    if (r == 0) return 8'd0;
    if (r == 1) return BLINK_CNT_MAX;
    if (r == 2) return 8'($urandom);
    return 8'($urandom_range(1, 5));
  endfunction

  function automatic cfg_t pick_cfg(int style);
    cfg_t c;
    c.flash_interval_ms      = pick_interval(style);
    c.fast_flash_interval_ms = pick_interval(style);
    c.short_blink_ms         = pick_interval(style);
    c.long_blink_ms          = pick_interval(style);
    c.max_short_blinks       = pick_cap(style);
    c.max_long_blinks        = pick_cap(style);
    return c;
  endfunction

  // mode bursts (repeated sets grow the blink count) followed by tick runs
  task automatic run_sequences(input int n_items);
    logic [2:0] m;
    int reps, ticks, sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom), 3'($urandom));
        sent++;
      end else begin
        if ($urandom_range(0, 15) == 0) m = 3'($urandom_range(MODE_SPARE6, MODE_SPARE7));
        else m = 3'($urandom_range(MODE_OFF, MODE_LONG));
        reps  = $urandom_range(1, 4);
        ticks = $urandom_range(1, 60);
        repeat (reps) send_item(KIND_SET, m);
        repeat (ticks) tick();
        sent += reps + ticks;
      end
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    cfg_t c;
    tick();
    send_item(KIND_SET, MODE_ON);
    tick();
    send_item(KIND_SET, MODE_ON);
    tick();
    send_item(KIND_SET, MODE_SPARE6);   // spare mode holds the lit LED
    tick();
    send_item(KIND_SET, MODE_SPARE7);
    tick();
    send_item(KIND_SET, MODE_OFF);
    tick();
    wait_drained();
    // zero intervals act every tick; a zero short limit never lights
    c = '{16'd0, 16'd1, 16'd0, 16'd1, 8'd0, BLINK_CNT_MAX};
    write_reg(CFG_SPARE6, 16'hFFFF);
    write_reg(CFG_SPARE7, 16'h5A5A);
    write_all(c);
    send_item(KIND_SET, MODE_FLASH);
    tick();
    tick();
    send_item(KIND_SET, MODE_FAST);
    tick();
    tick();
    send_item(KIND_SET, MODE_SHORT);
    tick();
    tick();
    send_item(KIND_SET, MODE_LONG);
    send_item(KIND_SET, MODE_LONG);
    repeat (5) tick();
  endtask

  // count must stick at its maximum rather than wrap
  task automatic test_count_saturation();
    cfg_t c;
    wait_drained();
    c = regs_model;
    c.short_blink_ms   = 16'd1;
    c.max_short_blinks = BLINK_CNT_MAX;
    write_all(c);
    send_item(KIND_SET, MODE_OFF);
    repeat (260) send_item(KIND_SET, MODE_SHORT);
    repeat (24) tick();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 9; p++) begin
      wait_drained();
      write_all(pick_cfg(p));
      run_sequences(120);
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    write_all(pick_cfg(2));
    hold_reqs <= hold_reqs + 1;
    send_item(KIND_SET, MODE_FAST);
    run_sequences(40);
    wait_drained();
    run_sequences(20);
  endtask

  task automatic test_steady_stream();
    wait_drained();
    idle_en = 1'b0;
    write_all(pick_cfg(2));
    run_sequences(150);
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_count_saturation();
    test_random_phases();
    test_backpressure();
    test_steady_stream();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
